FILE: rtl/running_stats_normalizer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the running statistics normalizer
// Shared immediate-implication and next-cycle-implication property forms.
// ----------------------------------------------------------------------------
`ifndef RUNNING_STATS_NORMALIZER_DEFINES_SVH
`define RUNNING_STATS_NORMALIZER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define RSN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define RSN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/rsn_pkg.sv
// ----------------------------------------------------------------------------
// rsn_pkg
// Types, constants and helpers shared by the normalizer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rsn_pkg;

  localparam int FEATURES_DEF = 64;

  // Datapath widths
  localparam int WIDE_W  = 128;
  localparam int MULA_W  = 65;
  localparam int DIVD_W  = 49;
  localparam int STEP_W  = 7;
  localparam int ROOT_W  = 32;

  // Serial step counts per operation
  localparam int MUL_STEPS  = 48;
  localparam int MDIV_STEPS = 49;
  localparam int BDIV_STEPS = 113;
  localparam int QDIV_STEPS = 114;
  localparam int SQRT_STEPS = 32;
  localparam int NDIV_STEPS = 53;

  // Statistics constants
  localparam logic [47:0] COUNT_RESET = 48'd7;
  localparam logic [47:0] ONE_Q16     = 48'd65536;
  localparam logic [47:0] COUNT_MAX   = 48'hFFFF_FFFF_FFFF;
  localparam logic [39:0] VAR_RESET   = 40'd65536;
  localparam logic [39:0] VAR_MAX     = 40'hFF_FFFF_FFFF;
  localparam logic [22:0] CLIP_RESET  = 23'd655360;

  // Configuration register indexes
  typedef enum logic {
    CFG_CLIP  = 1'b0,
    CFG_TRAIN = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_LAT,
    ST_LOAD,
    ST_MDIV,
    ST_SQ,
    ST_BM,
    ST_BD,
    ST_AM,
    ST_QD,
    ST_WB,
    ST_SQRT,
    ST_NDIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic               start;
    alu_op_t            op;
    logic [MULA_W-1:0]  a;
    logic [WIDE_W-1:0]  b;
    logic [DIVD_W-1:0]  d;
    logic [STEP_W-1:0]  steps;
  } alu_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WIDE_W-1:0] result;
  } alu_rsp_t;

  function automatic int idx_width(input int f);
    return (f > 1) ? $clog2(f) : 1;
  endfunction

endpackage

FILE: rtl/running_stats_normalizer.sv
// Throughput: one item at a time; a new word is taken once the sequencer is
// back in idle after the result word is registered. Item time is set by the
// shared bit-serial unit (one bit of a multiply or divide, one root digit per
// cycle); load words skip it, observe words without training skip the fold.
// Reset: synchronous active low; a clearing pass then writes every feature
// entry before the first input word is accepted.
// ----------------------------------------------------------------------------
// running_stats_normalizer
// Per-feature running mean and variance with clamped normalized output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "running_stats_normalizer_defines.svh"

module running_stats_normalizer #(
  parameter int FEATURES = rsn_pkg::FEATURES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  // tdata: feature_index, sample_value, preset_mean, preset_variance, pad
  input  logic [111:0]  in_tdata,
  // tuser: kind
  input  logic          in_tuser,
  input  logic          in_tlast,
  input  logic          in_tvalid,
  output logic          in_tready,
  // tdata: normalized_value, current_mean, current_variance, echo_index, pad
  output logic [103:0]  out_tdata,
  output logic          out_tlast,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [22:0]   cfg_data
);
  import rsn_pkg::*;

  localparam int IDXW = idx_width(FEATURES);

  state_t state_r, state_nxt;

  logic [IDXW-1:0] clr_r;
  logic [IDXW-1:0] idx_r;
  logic [10:0]     mod_r_c;
  logic [5:0]      fidx_r;
  logic            last_r;
  logic [31:0]     x_r, pmean_r, mean_r;
  logic [39:0]     pvar_r, var_r;
  logic [47:0]     count_r;
  logic [22:0]     clip_r;
  logic            train_r;
  logic [32:0]     mag_r;
  logic            neg_r;
  logic [112:0]    acc_r;
  logic [31:0]     s_r;
  logic [23:0]     norm_r;
  logic            launched_r;
  logic            out_valid_r;
  logic [103:0]    out_data_r;
  logic            out_last_r;

  logic            mem_we;
  logic [IDXW-1:0] mem_waddr;
  logic [31:0]     mem_wmean, rd_mean;
  logic [39:0]     mem_wvar, rd_var;

  alu_req_t        alu_req;
  alu_rsp_t        alu_rsp;
  logic            compute;
  logic            in_acc;

  logic [48:0]     total;
  logic [32:0]     fd, nd, nmag, step, qc_ext;
  logic [32:0]     mean_ext;
  logic [39:0]     vfloor;
  logic [113:0]    qsum;
  logic [22:0]     qc;

  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign total     = {1'b0, count_r} + {1'b0, ONE_Q16};

  // Feature index modulo FEATURES, one restoring step per index bit
  always_comb begin
    mod_r_c = '0;
    for (int i = 5; i >= 0; i--) begin
      mod_r_c = {mod_r_c[9:0], in_tdata[i]};
      if (mod_r_c >= 11'(FEATURES)) mod_r_c = mod_r_c - 11'(FEATURES);
    end
  end

  // Deltas for the fold step and the normalize step
  assign fd       = {x_r[31], x_r} - {rd_mean[31], rd_mean};
  assign nd       = {x_r[31], x_r} - {mean_r[31], mean_r};
  assign nmag     = nd[32] ? (~nd + 33'd1) : nd;
  assign step     = alu_rsp.result[32:0];
  assign mean_ext = {mean_r[31], mean_r};
  assign vfloor   = (var_r == '0) ? 40'd1 : var_r;
  assign qsum     = 114'(alu_rsp.result[112:0]) + 114'(acc_r);
  assign qc       = (alu_rsp.result[52:0] > 53'(clip_r)) ? clip_r : alu_rsp.result[22:0];
  assign qc_ext   = 33'(qc);

  rsn_stat_mem #(
    .FEATURES (FEATURES)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wmean (mem_wmean),
    .wvar  (mem_wvar),
    .raddr (idx_r),
    .rmean (rd_mean),
    .rvar  (rd_var)
  );

  rsn_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == IDXW'(FEATURES - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_acc) state_nxt = in_tuser ? ST_LOAD : ST_RD;
      ST_RD:    state_nxt = ST_LAT;
      ST_LAT:   state_nxt = train_r ? ST_MDIV : ST_SQRT;
      ST_LOAD:  state_nxt = ST_OUT;
      ST_MDIV:  if (alu_rsp.done) state_nxt = ST_SQ;
      ST_SQ:    if (alu_rsp.done) state_nxt = ST_BM;
      ST_BM:    if (alu_rsp.done) state_nxt = ST_BD;
      ST_BD:    if (alu_rsp.done) state_nxt = ST_AM;
      ST_AM:    if (alu_rsp.done) state_nxt = ST_QD;
      ST_QD:    if (alu_rsp.done) state_nxt = ST_WB;
      ST_WB:    state_nxt = ST_SQRT;
      ST_SQRT:  if (alu_rsp.done) state_nxt = ST_NDIV;
      ST_NDIV:  if (alu_rsp.done) state_nxt = ST_OUT;
      ST_OUT:   if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory write and unit requests
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wmean = mean_r;
    mem_wvar  = var_r;
    alu_req   = '0;
    compute   = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wmean = '0;
        mem_wvar  = VAR_RESET;
      end
      ST_LOAD: begin
        mem_we    = 1'b1;
        mem_wmean = pmean_r;
        mem_wvar  = pvar_r;
      end
      ST_WB: mem_we = 1'b1;
      ST_MDIV: begin
        compute       = 1'b1;
        alu_req.op    = OP_DIV;
        alu_req.b     = WIDE_W'({mag_r, 16'b0}) << (WIDE_W - MDIV_STEPS);
        alu_req.d     = total;
        alu_req.steps = STEP_W'(MDIV_STEPS);
      end
      ST_SQ: begin
        compute       = 1'b1;
        alu_req.op    = OP_MUL;
        alu_req.a     = MULA_W'(mag_r);
        alu_req.b     = WIDE_W'(mag_r);
        alu_req.steps = STEP_W'(MUL_STEPS);
      end
      ST_BM: begin
        compute       = 1'b1;
        alu_req.op    = OP_MUL;
        alu_req.a     = alu_rsp.result[MULA_W-1:0];
        alu_req.b     = WIDE_W'(count_r);
        alu_req.steps = STEP_W'(MUL_STEPS);
      end
      ST_BD: begin
        compute       = 1'b1;
        alu_req.op    = OP_DIV;
        alu_req.b     = WIDE_W'(alu_rsp.result[112:0]) << (WIDE_W - BDIV_STEPS);
        alu_req.d     = total;
        alu_req.steps = STEP_W'(BDIV_STEPS);
      end
      ST_AM: begin
        compute       = 1'b1;
        alu_req.op    = OP_MUL;
        alu_req.a     = MULA_W'(var_r);
        alu_req.b     = WIDE_W'(count_r);
        alu_req.steps = STEP_W'(MUL_STEPS);
      end
      ST_QD: begin
        compute       = 1'b1;
        alu_req.op    = OP_DIV;
        alu_req.b     = WIDE_W'(qsum) << (WIDE_W - QDIV_STEPS);
        alu_req.d     = total;
        alu_req.steps = STEP_W'(QDIV_STEPS);
      end
      ST_SQRT: begin
        compute       = 1'b1;
        alu_req.op    = OP_SQRT;
        alu_req.b     = {vfloor, 24'b0, 64'b0};
        alu_req.steps = STEP_W'(SQRT_STEPS);
      end
      ST_NDIV: begin
        compute       = 1'b1;
        alu_req.op    = OP_DIV;
        alu_req.b     = WIDE_W'({nmag, 20'b0}) << (WIDE_W - NDIV_STEPS);
        alu_req.d     = DIVD_W'(s_r);
        alu_req.steps = STEP_W'(NDIV_STEPS);
      end
      default: ;
    endcase
    alu_req.start = compute && !launched_r;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= COUNT_RESET;
      clip_r      <= CLIP_RESET;
      train_r     <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + IDXW'(1);
      if (alu_rsp.done) launched_r <= 1'b0;
      else if (alu_req.start) launched_r <= 1'b1;
      // Hold the output word until taken
      if (state_r == ST_OUT && (!out_valid_r || out_tready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      // Shared count: reset on load, advance on the last element of a training observation
      if (state_r == ST_LOAD) count_r <= COUNT_RESET;
      else if (state_r == ST_WB && last_r) begin
        count_r <= (count_r > (COUNT_MAX - ONE_Q16)) ? COUNT_MAX : count_r + ONE_Q16;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_CLIP:  clip_r  <= cfg_data;
          CFG_TRAIN: train_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Item and working payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      last_r  <= in_tlast;
      fidx_r  <= in_tdata[5:0];
      idx_r   <= mod_r_c[IDXW-1:0];
      x_r     <= in_tdata[37:6];
      pmean_r <= in_tdata[69:38];
      pvar_r  <= in_tdata[109:70];
    end
    unique case (state_r)
      ST_LOAD: begin
        mean_r <= pmean_r;
        var_r  <= pvar_r;
        norm_r <= '0;
      end
      ST_LAT: begin
        mean_r <= rd_mean;
        var_r  <= rd_var;
        neg_r  <= fd[32];
        mag_r  <= fd[32] ? (~fd + 33'd1) : fd;
      end
      ST_MDIV: if (alu_rsp.done) begin
        mean_r <= neg_r ? 32'(mean_ext - step) : 32'(mean_ext + step);
      end
      ST_BD: if (alu_rsp.done) acc_r <= alu_rsp.result[112:0];
      ST_QD: if (alu_rsp.done) begin
        var_r <= (alu_rsp.result > WIDE_W'(VAR_MAX)) ? VAR_MAX : alu_rsp.result[39:0];
      end
      ST_SQRT: if (alu_rsp.done) s_r <= alu_rsp.result[31:0];
      ST_NDIV: if (alu_rsp.done) begin
        norm_r <= nd[32] ? 24'(~qc_ext + 33'd1) : 24'(qc_ext);
      end
      default: ;
    endcase
    if (state_r == ST_OUT && (!out_valid_r || out_tready)) begin
      out_data_r <= {2'b00, fidx_r, var_r, mean_r, norm_r};
      out_last_r <= last_r;
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tvalid = out_valid_r;

  `RSN_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_r != ST_IDLE,
                   "accepted word left sequencer idle")
  `RSN_ASSERT_NOW(a_count_floor, state_r != ST_CLEAR, count_r >= COUNT_RESET,
                  "sample count below its reset value")
  `RSN_ASSERT_NOW(a_done_in_compute, alu_rsp.done,
                  state_r == ST_MDIV || state_r == ST_SQ || state_r == ST_BM ||
                  state_r == ST_BD || state_r == ST_AM || state_r == ST_QD ||
                  state_r == ST_SQRT || state_r == ST_NDIV,
                  "serial unit finished outside a compute state")

endmodule

FILE: rtl/rsn_stat_mem.sv
// ----------------------------------------------------------------------------
// rsn_stat_mem
// Per-feature mean and variance storage, one write and one registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsn_stat_mem #(
  parameter int FEATURES = rsn_pkg::FEATURES_DEF
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [rsn_pkg::idx_width(FEATURES)-1:0]   waddr,
  input  logic [31:0]                               wmean,
  input  logic [39:0]                               wvar,
  input  logic [rsn_pkg::idx_width(FEATURES)-1:0]   raddr,
  output logic [31:0]                               rmean,
  output logic [39:0]                               rvar
);
  import rsn_pkg::*;

  logic [31:0] mean_mem [FEATURES];
  logic [39:0] var_mem  [FEATURES];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mean_mem[waddr] <= wmean;
      var_mem[waddr]  <= wvar;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rmean <= mean_mem[raddr];
    rvar  <= var_mem[raddr];
  end

endmodule

FILE: rtl/rsn_alu.sv
// ----------------------------------------------------------------------------
// rsn_alu
// Shared bit-serial unit: shift-add multiply, restoring divide, square root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "running_stats_normalizer_defines.svh"

module rsn_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  rsn_pkg::alu_req_t req,
  output rsn_pkg::alu_rsp_t rsp
);
  import rsn_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  alu_op_t           op_r;
  logic [MULA_W-1:0] a_r;
  logic [DIVD_W-1:0] d_r;
  logic [WIDE_W-1:0] w_r, w_nxt;
  logic [MULA_W-1:0] hi_r, hi_nxt;
  logic [DIVD_W-1:0] rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;

  logic [MULA_W:0]   msum;
  logic [DIVD_W:0]   dtrial;
  logic [ROOT_W+2:0] strial;
  logic [ROOT_W+2:0] sroot;

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // One digit per cycle for the selected operation
  always_comb begin
    w_nxt    = w_r;
    hi_nxt   = hi_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    msum     = {1'b0, hi_r} + (w_r[0] ? {1'b0, a_r} : '0);
    dtrial   = {rem_r, w_r[WIDE_W-1]};
    strial   = {rem_r[ROOT_W:0], w_r[WIDE_W-1 -: 2]};
    sroot    = {1'b0, root_r, 2'b01};
    unique case (op_r)
      OP_MUL: begin
        hi_nxt = msum[MULA_W:1];
        w_nxt  = {w_r[WIDE_W-1:MUL_STEPS], msum[0], w_r[MUL_STEPS-1:1]};
      end
      OP_DIV: begin
        if (dtrial >= {1'b0, d_r}) begin
          rem_nxt = DIVD_W'(dtrial - {1'b0, d_r});
          w_nxt   = {w_r[WIDE_W-2:0], 1'b1};
        end else begin
          rem_nxt = dtrial[DIVD_W-1:0];
          w_nxt   = {w_r[WIDE_W-2:0], 1'b0};
        end
      end
      OP_SQRT: begin
        w_nxt = {w_r[WIDE_W-3:0], 2'b00};
        if (strial >= sroot) begin
          rem_nxt  = DIVD_W'(strial - sroot);
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = DIVD_W'(strial);
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // Operand and working registers
  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      op_r   <= req.op;
      a_r    <= req.a;
      d_r    <= req.d;
      w_r    <= req.b;
      hi_r   <= '0;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      w_r    <= w_nxt;
      hi_r   <= hi_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  always_comb begin
    rsp.busy = busy_r;
    rsp.done = done_r;
    unique case (op_r)
      OP_MUL:  rsp.result = WIDE_W'({hi_r, w_r[MUL_STEPS-1:0]});
      OP_DIV:  rsp.result = w_r;
      OP_SQRT: rsp.result = WIDE_W'(root_r);
      default: rsp.result = w_r;
    endcase
  end

  `RSN_ASSERT_NEXT(a_done_after_busy, done_r, !busy_r, "alu busy right after done")
  `RSN_ASSERT_NOW(a_busy_count, busy_r, cnt_r != '0, "alu busy with zero step count")
  `RSN_ASSERT_NEXT(a_start_busy, req.start && !busy_r && req.steps != '0, busy_r,
                   "alu start not taken")

endmodule

FILE: tb/running_stats_normalizer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_stats_normalizer_checker
// Watches the input, configuration and result channels of the normalizer.
// Keeps its own per-feature mean and variance tables and shared count,
// predicts one result word per accepted input word, and compares each result
// word field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module running_stats_normalizer_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [111:0] in_tdata,
  input  logic         in_tuser,
  input  logic         in_tlast,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [103:0] out_tdata,
  input  logic         out_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [22:0]  cfg_data,
  output int           errors,
  output int           outstanding
);
  import rsn_pkg::*;

  typedef struct {
    logic [23:0] norm;
    logic [31:0] mean;
    logic [39:0] var_q;
    logic [5:0]  idx;
    logic        last;
  } norm_result_t;

  logic signed [31:0] mean_tbl [FEATURES_DEF];
  logic [39:0]        var_tbl  [FEATURES_DEF];
  logic [47:0]        shared_count;
  logic [22:0]        clip_q;
  logic               train_on;
  norm_result_t       expected_q [$];

  // Integer square root of a 64-bit value, digit by digit
  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Fold one sample into a feature's mean and variance
  task automatic fold_stats(input int f, input logic signed [63:0] x);
    logic signed [63:0] mean;
    logic signed [63:0] delta;
    logic [63:0]        mag;
    logic [63:0]        total;
    logic [63:0]        step;
    logic [127:0]       acc;
    logic [127:0]       frac;
    logic [127:0]       q;
    mean  = mean_tbl[f];
    total = 64'(shared_count) + 64'(ONE_Q16);
    delta = x - mean;
    mag   = delta < 0 ? -delta : delta;
    step  = (mag << 16) / total;
    mean_tbl[f] = 32'(delta < 0 ? mean - step : mean + step);
    acc  = 128'(var_tbl[f]) * 128'(shared_count);
    frac = (128'(mag * mag) * 128'(shared_count)) / 128'(total);
    q    = (acc + frac) / 128'(total);
    var_tbl[f] = (q > 128'(VAR_MAX)) ? VAR_MAX : q[39:0];
  endtask

  // Predict the result word of one input word
  task automatic predict_item(input logic kind, input logic [5:0] fidx,
                              input logic signed [31:0] x, input logic [31:0] pm,
                              input logic [39:0] pv, input logic last);
    norm_result_t       r;
    int                 f;
    logic [39:0]        v;
    logic [63:0]        s;
    logic signed [63:0] d;
    logic [63:0]        mag;
    logic [63:0]        q;
    f = fidx % FEATURES_DEF;
    r.norm = '0;
    if (kind) begin
      mean_tbl[f]  = pm;
      var_tbl[f]   = pv;
      shared_count = COUNT_RESET;
    end else begin
      if (train_on) begin
        fold_stats(f, x);
        if (last) begin
          shared_count = (shared_count > COUNT_MAX - ONE_Q16) ? COUNT_MAX
                                                               : shared_count + ONE_Q16;
        end
      end
      v = (var_tbl[f] == 0) ? 40'd1 : var_tbl[f];
      s = int_sqrt({v, 24'd0});
      d = 64'(x) - 64'(mean_tbl[f]);
      mag = d < 0 ? -d : d;
      q = (mag << 20) / s;
      if (q > 64'(clip_q)) q = 64'(clip_q);
      r.norm = d < 0 ? 24'(-q) : q[23:0];
    end
    r.mean  = mean_tbl[f];
    r.var_q = var_tbl[f];
    r.idx   = fidx;
    r.last  = last;
    expected_q.push_back(r);
  endtask

  // Sample all three channels on the clock edge
  always @(posedge clk) begin
    norm_result_t e;
    if (!rst_n) begin
      for (int i = 0; i < FEATURES_DEF; i++) begin
        mean_tbl[i] = '0;
        var_tbl[i]  = VAR_RESET;
      end
      shared_count = COUNT_RESET;
      clip_q       = CLIP_RESET;
      train_on     = 1'b1;
      errors       = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CLIP) clip_q = cfg_data;
        else train_on = cfg_data[0];
      end
      if (in_tvalid && in_tready)
        predict_item(in_tuser, in_tdata[5:0], in_tdata[37:6], in_tdata[69:38],
                     in_tdata[109:70], in_tlast);
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %h", out_tdata);
        end else begin
          e = expected_q.pop_front();
          if (out_tdata[23:0] !== e.norm || out_tdata[55:24] !== e.mean ||
              out_tdata[95:56] !== e.var_q || out_tdata[101:96] !== e.idx ||
              out_tlast !== e.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp norm %h mean %h var %h idx %0d last %b, got %h %h %h %0d %b",
                       e.norm, e.mean, e.var_q, e.idx, e.last, out_tdata[23:0],
                       out_tdata[55:24], out_tdata[95:56], out_tdata[101:96], out_tlast);
          end
        end
      end
    end
    outstanding = expected_q.size();
  end

endmodule

FILE: tb/tb_running_stats_normalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_running_stats_normalizer
// Drives directed and random observe and load words into the normalizer with
// random gaps and back-pressure, writes both registers between phases, and
// reports the checker's verdict.
// ----------------------------------------------------------------------------

module tb_running_stats_normalizer;
  import rsn_pkg::*;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic [111:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         in_tlast = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [103:0] out_tdata;
  logic         out_tlast;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_index = CFG_CLIP;
  logic [22:0]  cfg_data = '0;
  int           errors;
  int           outstanding;
  int           send_idle_pct = 17;
  int           recv_idle_pct = 88;
  int           words_sent = 0;

  running_stats_normalizer dut (.*);

  running_stats_normalizer_checker chk (.*);

  always #2 clk = ~clk;

  // Random back-pressure on the result side
  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  // Present one word and hold it until accepted
  task automatic send_word(input logic kind, input logic [5:0] fidx,
                           input logic [31:0] x, input logic [31:0] pm,
                           input logic [39:0] pv, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tdata  <= {2'b00, pv, pm, x, fidx};
    in_tuser  <= kind;
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // Stop sending and wait until every result word is back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [22:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One observation vector over consecutive features near a center value
  task automatic send_observation();
    int          n;
    logic [5:0]  base;
    logic [31:0] center;
    n = $urandom_range(1, 8);
    base = 6'($urandom_range(0, 15));
    center = $urandom_range(1, 4) == 1 ? $urandom : 32'($signed($urandom_range(0, 40000)) - 20000) <<< $urandom_range(0, 8);
    for (int i = 0; i < n; i++)
      send_word(1'b0, base + 6'(i), center + 32'($signed($urandom_range(0, 8191)) - 4096) * $urandom_range(0, 64),
                $urandom, 40'({$urandom, $urandom}), i == n - 1);
  endtask

  task automatic random_phase(input int words);
    int goal;
    int pick;
    goal = words_sent + words;
    while (words_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        send_observation();
      end else if (pick < 90) begin
        send_word(1'b1, 6'($urandom), $urandom,
                  32'($signed($urandom_range(0, 200000)) - 100000) <<< $urandom_range(0, 12),
                  $urandom_range(0, 3) == 0 ? 40'({$urandom, $urandom}) :
                  40'($urandom_range(0, 1 << 20)), 1'($urandom));
      end else begin
        send_word(1'($urandom), 6'($urandom), $urandom, $urandom, 40'({$urandom, $urandom}),
                  1'($urandom));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, both kinds, zero and saturated variance, clip range
    write_reg(CFG_CLIP, 23'd0);
    write_reg(CFG_TRAIN, 23'd0);
    send_word(1'b1, 6'd0, 32'h0, 32'h0001_0000, 40'd0, 1'b1);
    send_word(1'b0, 6'd0, 32'h7FFF_FFFF, 32'h0, 40'h0, 1'b0);
    drain();
    write_reg(CFG_CLIP, 23'h7F_FFFF);
    send_word(1'b0, 6'd0, 32'h8000_0000, 32'h0, 40'h0, 1'b1);
    send_word(1'b0, 6'd63, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 1'b0);
    send_word(1'b1, 6'd63, 32'h0, 32'h8000_0000, 40'hFF_FFFF_FFFF, 1'b0);
    send_word(1'b1, 6'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 40'hFF_FFFF_FFFF, 1'b1);
    drain();
    write_reg(CFG_TRAIN, 23'd1);
    send_word(1'b0, 6'd63, 32'h7FFF_FFFF, 32'h0, 40'h0, 1'b0);
    send_word(1'b0, 6'd1, 32'h8000_0000, 32'h0, 40'h0, 1'b1);
    send_word(1'b0, 6'd1, 32'h7FFF_FFFF, 32'h0, 40'h0, 1'b1);
    send_word(1'b1, 6'd2, 32'h0, 32'h0003_0000, 40'd0, 1'b0);
    send_word(1'b0, 6'd2, 32'h0003_0000, 32'h0, 40'h0, 1'b1);
    send_word(1'b0, 6'd2, 32'h0003_0001, 32'h0, 40'h0, 1'b0);
    send_word(1'b0, 6'd3, 32'h0, 32'h0, 40'h0, 1'b1);
    drain();
    write_reg(CFG_CLIP, CLIP_RESET);

    random_phase(270);
    drain();
    send_idle_pct = 88;
    recv_idle_pct = 17;
    write_reg(CFG_CLIP, 23'($urandom_range(1, 8388607)));
    write_reg(CFG_TRAIN, 23'd0);
    random_phase(60);
    drain();
    write_reg(CFG_TRAIN, 23'd1);
    random_phase(220);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_CLIP, 23'h7F_FFFF);
    random_phase(280);
    drain();

    repeat (600) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("tb_running_stats_normalizer: clean");
    end else begin
      $display("tb_running_stats_normalizer: errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_running_stats_normalizer: errors");
    $finish;
  end

endmodule
